>>> rtl/dda_pkg.sv
// ----------------------------------------------------------------------------
// dda_pkg
// Shared types and constants of the DDA line rasterizer: word formats of the
// input and result queues and the command passed from front to back.
// ----------------------------------------------------------------------------
package dda_pkg;

  // Coordinate width is fixed by the word formats
  localparam int unsigned COORD_BITS    = 10;
  // Default number of fraction bits in increments and accumulators
  localparam int unsigned DEF_FRAC_BITS = 16;
  // Entries in the command queue between front and back
  localparam int unsigned QUEUE_DEPTH   = 2;

  // Function codes of an input word
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  // Input word
  typedef struct packed {
    logic                  func;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic                  valid_res;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  last;
  } out_word_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic                  is_step;
    logic [COORD_BITS-1:0] xs;
    logic [COORD_BITS-1:0] ys;
    logic [COORD_BITS-1:0] steps;
    logic [COORD_BITS-1:0] mag_x;
    logic [COORD_BITS-1:0] mag_y;
    logic                  neg_x;
    logic                  neg_y;
  } cmd_t;

endpackage

>>> rtl/dda_line_rasterizer.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line rasterizer, top level.
//
// Input queue: push_i/full_o carry an in_word_t. func = start loads two
// endpoints and returns the first point; func = step returns the next point
// of the line (valid_res = 0 when no line is active). Result queue:
// empty_o/pop_i; every input word gives exactly one result word, in order.
// A front stage classifies words into a two-entry command queue; the back
// stage executes them into a one-word result register.
// A step word passes through the command queue and the result register to
// out_word_o. A start word with distinct endpoints first runs the two
// increment dividers, so its first point waits for both quotients. Step
// words sustain one point per cycle while no division runs and pop_i is high.
// When the receiver holds pop_i low, the result register and then the
// command queue fill, and full_o rises. Reset empties both queues and
// leaves no line active.
// ----------------------------------------------------------------------------
module dda_line_rasterizer #(
  parameter int unsigned FRAC_BITS = dda_pkg::DEF_FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  dda_pkg::in_word_t  in_word_i,
  output logic               empty_o,
  input  logic               pop_i,
  output dda_pkg::out_word_t out_word_o
);
  import dda_pkg::*;

  cmd_t               front_cmd;
  cmd_t               head_cmd;
  logic               q_push;
  logic               q_full;
  logic               q_valid;
  logic               q_pop;
  logic               div_start;
  logic               div_busy_x;
  logic               div_busy_y;
  logic [FRAC_BITS:0] quo_x;
  logic [FRAC_BITS:0] quo_y;

  assign full_o = q_full;
  assign q_push = push_i && !q_full;

  // classification
  dda_front u_front (
    .in_word_i (in_word_i),
    .cmd_o     (front_cmd)
  );

  // command queue
  dda_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  // increment dividers, x and y
  dda_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .mag_i   (head_cmd.mag_x),
    .steps_i (head_cmd.steps),
    .busy_o  (div_busy_x),
    .quo_o   (quo_x)
  );

  dda_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .mag_i   (head_cmd.mag_y),
    .steps_i (head_cmd.steps),
    .busy_o  (div_busy_y),
    .quo_o   (quo_y)
  );

  // execution and result register
  dda_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (q_pop),
    .div_start_o (div_start),
    .div_busy_i  (div_busy_x || div_busy_y),
    .quo_x_i     (quo_x),
    .quo_y_i     (quo_y),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .out_word_o  (out_word_o)
  );

endmodule

>>> rtl/dda_front.sv
// ----------------------------------------------------------------------------
// dda_front
// Classifies an input word: step or start, and for a start the deltas,
// their signs and magnitudes, and the step count max(|dx|, |dy|).
// ----------------------------------------------------------------------------
module dda_front (
  input  dda_pkg::in_word_t in_word_i,
  output dda_pkg::cmd_t     cmd_o
);
  import dda_pkg::*;

  logic [COORD_BITS:0]   dx;
  logic [COORD_BITS:0]   dy;
  logic [COORD_BITS:0]   dx_neg;
  logic [COORD_BITS:0]   dy_neg;
  logic [COORD_BITS-1:0] mag_x;
  logic [COORD_BITS-1:0] mag_y;

  // signed deltas, one extra bit for the sign
  assign dx     = {1'b0, in_word_i.x_end} - {1'b0, in_word_i.x_start};
  assign dy     = {1'b0, in_word_i.y_end} - {1'b0, in_word_i.y_start};
  assign dx_neg = ~dx + 1'b1;
  assign dy_neg = ~dy + 1'b1;

  // magnitudes fit the coordinate width
  assign mag_x = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
  assign mag_y = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];

  // command assembly
  always_comb begin
    cmd_o.is_step = (in_word_i.func == FUNC_STEP);
    cmd_o.xs      = in_word_i.x_start;
    cmd_o.ys      = in_word_i.y_start;
    cmd_o.mag_x   = mag_x;
    cmd_o.mag_y   = mag_y;
    cmd_o.neg_x   = dx[COORD_BITS];
    cmd_o.neg_y   = dy[COORD_BITS];
    cmd_o.steps   = (mag_x > mag_y) ? mag_x : mag_y;
  end

endmodule

>>> rtl/dda_queue.sv
// ----------------------------------------------------------------------------
// dda_queue
// Short command queue between front and back, first in first out.
// ----------------------------------------------------------------------------
module dda_queue #(
  parameter int unsigned DEPTH = dda_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dda_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output dda_pkg::cmd_t cmd_o
);
  import dda_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");
  a_push_notfull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> count_q != '0)
    else $error("push lost");

endmodule

>>> rtl/dda_div.sv
// ----------------------------------------------------------------------------
// dda_div
// Restoring divider, one quotient bit per cycle: (mag << FRAC_BITS) / steps.
// It runs while busy_o is high; the result holds until the next start.
// ----------------------------------------------------------------------------
module dda_div #(
  parameter int unsigned FRAC_BITS = dda_pkg::DEF_FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [dda_pkg::COORD_BITS-1:0] mag_i,
  input  logic [dda_pkg::COORD_BITS-1:0] steps_i,
  output logic                           busy_o,
  output logic [FRAC_BITS:0]             quo_o
);
  import dda_pkg::*;

  localparam int unsigned NB    = COORD_BITS + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(NB + 1);

  logic                  busy_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [NB-1:0]         num_q;
  logic [NB-1:0]         quo_q;
  logic [COORD_BITS-1:0] rem_q;
  logic [COORD_BITS-1:0] div_q;
  logic [COORD_BITS:0]   trial;
  logic [COORD_BITS:0]   diff;
  logic                  qbit;

  // one trial subtraction per cycle
  assign trial = {rem_q, num_q[NB-1]};
  assign diff  = trial - {1'b0, div_q};
  assign qbit  = (trial >= {1'b0, div_q});

  assign busy_o = busy_q;
  // quotient never exceeds 2^FRAC_BITS since mag <= steps
  assign quo_o  = quo_q[FRAC_BITS:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(NB);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {mag_i, {FRAC_BITS{1'b0}}};
      rem_q <= '0;
      quo_q <= '0;
      div_q <= steps_i;
    end else if (busy_q) begin
      num_q <= {num_q[NB-2:0], 1'b0};
      rem_q <= qbit ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
      quo_q <= {quo_q[NB-2:0], qbit};
    end
  end

endmodule

>>> rtl/dda_back.sv
// ----------------------------------------------------------------------------
// dda_back
// Carries out commands: loads a line, runs the two increment divisions,
// steps the accumulators and fills the result register.
// ----------------------------------------------------------------------------
module dda_back #(
  parameter int unsigned FRAC_BITS = dda_pkg::DEF_FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command queue head
  input  logic               cmd_valid_i,
  input  dda_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  // dividers
  output logic               div_start_o,
  input  logic               div_busy_i,
  input  logic [FRAC_BITS:0] quo_x_i,
  input  logic [FRAC_BITS:0] quo_y_i,
  // result side
  output logic               empty_o,
  input  logic               pop_i,
  output dda_pkg::out_word_t out_word_o
);
  import dda_pkg::*;

  localparam int unsigned ACC_W = COORD_BITS + FRAC_BITS + 1;
  localparam int unsigned INC_W = FRAC_BITS + 2;
  localparam logic [ACC_W:0] HALF = (ACC_W + 1)'(1) << (FRAC_BITS - 1);

  typedef enum logic {S_RUN, S_DIV} state_e;

  state_e                state_q, state_d;
  logic [ACC_W-1:0]      acc_x_q, acc_x_d;
  logic [ACC_W-1:0]      acc_y_q, acc_y_d;
  logic [INC_W-1:0]      inc_x_q, inc_x_d;
  logic [INC_W-1:0]      inc_y_q, inc_y_d;
  logic [COORD_BITS-1:0] pts_q, pts_d;
  logic [COORD_BITS-1:0] steps_q, steps_d;
  logic                  active_q, active_d;
  logic                  neg_x_q, neg_x_d;
  logic                  neg_y_q, neg_y_d;
  logic                  out_valid_q, out_valid_d;
  out_word_t             out_q, out_d;
  logic                  out_free;
  logic                  emit;
  out_word_t             emit_word;
  logic [INC_W-1:0]      new_inc_x;
  logic [INC_W-1:0]      new_inc_y;

  // floor(acc + 0.5), saturated to the coordinate range
  function automatic logic [COORD_BITS-1:0] round_coord(input logic [ACC_W-1:0] acc);
    logic [ACC_W:0]        v;
    logic [COORD_BITS-1:0] r;
    v = {acc[ACC_W-1], acc} + HALF;
    if (v[ACC_W]) begin
      r = '0;
    end else if (v[FRAC_BITS+COORD_BITS]) begin
      r = '1;
    end else begin
      r = v[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
    end
    return r;
  endfunction

  // sign-extend an increment to accumulator width
  function automatic logic [ACC_W-1:0] ext_inc(input logic [INC_W-1:0] inc);
    return {{(ACC_W - INC_W){inc[INC_W-1]}}, inc};
  endfunction

  // signed increments from the divider magnitudes
  assign new_inc_x = neg_x_q ? (~{1'b0, quo_x_i} + 1'b1) : {1'b0, quo_x_i};
  assign new_inc_y = neg_y_q ? (~{1'b0, quo_y_i} + 1'b1) : {1'b0, quo_y_i};

  assign out_free   = !out_valid_q || pop_i;
  assign empty_o    = !out_valid_q;
  assign out_word_o = out_q;

  // command sequencing
  always_comb begin
    state_d     = state_q;
    acc_x_d     = acc_x_q;
    acc_y_d     = acc_y_q;
    inc_x_d     = inc_x_q;
    inc_y_d     = inc_y_q;
    pts_d       = pts_q;
    steps_d     = steps_q;
    active_d    = active_q;
    neg_x_d     = neg_x_q;
    neg_y_d     = neg_y_q;
    cmd_pop_o   = 1'b0;
    div_start_o = 1'b0;
    emit        = 1'b0;
    emit_word   = '0;

    unique case (state_q)
      S_RUN: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.is_step) begin
            emit = 1'b1;
            if (active_q) begin
              emit_word.valid_res = 1'b1;
              emit_word.point_x   = round_coord(acc_x_q);
              emit_word.point_y   = round_coord(acc_y_q);
              emit_word.last      = (pts_q == COORD_BITS'(1));
              pts_d   = pts_q - 1'b1;
              acc_x_d = acc_x_q + ext_inc(inc_x_q);
              acc_y_d = acc_y_q + ext_inc(inc_y_q);
              if (pts_q == COORD_BITS'(1)) begin
                active_d = 1'b0;
              end
            end
          end else begin
            acc_x_d  = {1'b0, cmd_i.xs, {FRAC_BITS{1'b0}}};
            acc_y_d  = {1'b0, cmd_i.ys, {FRAC_BITS{1'b0}}};
            active_d = 1'b0;
            if (cmd_i.steps == '0) begin
              // equal endpoints: a single point, no division
              inc_x_d = '0;
              inc_y_d = '0;
              pts_d   = '0;
              emit    = 1'b1;
              emit_word.valid_res = 1'b1;
              emit_word.point_x   = cmd_i.xs;
              emit_word.point_y   = cmd_i.ys;
              emit_word.last      = 1'b1;
            end else begin
              div_start_o = 1'b1;
              neg_x_d     = cmd_i.neg_x;
              neg_y_d     = cmd_i.neg_y;
              steps_d     = cmd_i.steps;
              state_d     = S_DIV;
            end
          end
        end
      end
      S_DIV: begin
        // increments ready: emit the first point and start stepping
        if (!div_busy_i && out_free) begin
          emit = 1'b1;
          emit_word.valid_res = 1'b1;
          emit_word.point_x   = round_coord(acc_x_q);
          emit_word.point_y   = round_coord(acc_y_q);
          emit_word.last      = 1'b0;
          inc_x_d  = new_inc_x;
          inc_y_d  = new_inc_y;
          acc_x_d  = acc_x_q + ext_inc(new_inc_x);
          acc_y_d  = acc_y_q + ext_inc(new_inc_y);
          pts_d    = steps_q;
          active_d = 1'b1;
          state_d  = S_RUN;
        end
      end
      default: state_d = S_RUN;
    endcase

    // result register
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = emit_word;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      inc_x_q     <= '0;
      inc_y_q     <= '0;
      pts_q       <= '0;
      steps_q     <= '0;
      active_q    <= 1'b0;
      neg_x_q     <= 1'b0;
      neg_y_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      acc_x_q     <= acc_x_d;
      acc_y_q     <= acc_y_d;
      inc_x_q     <= inc_x_d;
      inc_y_q     <= inc_y_d;
      pts_q       <= pts_d;
      steps_q     <= steps_d;
      active_q    <= active_d;
      neg_x_q     <= neg_x_d;
      neg_y_q     <= neg_y_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // checks
  a_active_pts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> pts_q != '0)
    else $error("active line with no points left");
  a_div_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> !cmd_pop_o)
    else $error("command popped during division");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && emit_word.last |=> !active_q)
    else $error("line still active after last point");

endmodule

>>> verif/tb_dda_line_rasterizer.sv
// ----------------------------------------------------------------------------
// tb_dda_line_rasterizer
// Self-checking testbench of the DDA line rasterizer. A directed table covers
// the endpoint extremes, equal endpoints, step words with no line, and
// restarts in mid-line. Random line sequences with random gaps on both queue
// sides follow, plus one long receiver hold that backs the block up. Result
// words are compared to typed rows or an in-bench fixed-point line predictor.
// ----------------------------------------------------------------------------
module tb_dda_line_rasterizer;
  import dda_pkg::*;

  localparam int unsigned FRAC      = DEF_FRAC_BITS;
  localparam int unsigned ACC_W     = COORD_BITS + FRAC + 1;
  localparam int unsigned INC_W     = FRAC + 2;
  localparam int          COORD_MAX = (1 << COORD_BITS) - 1;
  localparam int          N_RANDOM  = 450;
  localparam int          HOLD_CYC  = 300;
  localparam int          DRAIN_CYC = 60;
  localparam int          IDLE_MAX  = 3000;

  // Directed table row: word, and a hand-typed expectation where obvious
  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t res;
  } dir_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      push_i;
  logic      full_o;
  in_word_t  in_word_i;
  logic      empty_o;
  logic      pop_i;
  out_word_t out_word_o;

  // Line predictor state
  logic signed [ACC_W-1:0] ln_acc_x;
  logic signed [ACC_W-1:0] ln_acc_y;
  logic signed [INC_W-1:0] ln_inc_x;
  logic signed [INC_W-1:0] ln_inc_y;
  logic [COORD_BITS:0]     ln_left;
  logic                    ln_active;

  out_word_t  point_q[$];
  dir_row_t   dir_rows[$];
  out_word_t  got_w;
  out_word_t  want_w;

  int  n_errors;
  int  n_words;
  int  n_points;
  int  n_lines;
  int  n_full;
  int  idle_cnt;
  bit  running;
  bit  hold_req;
  bit  hold_done;
  bit  hold_busy;

  dda_line_rasterizer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .full_o     (full_o),
    .in_word_i  (in_word_i),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .out_word_o (out_word_o)
  );

  // Clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Signed increment: (d << FRAC) / steps, truncated toward zero
  function automatic logic signed [INC_W-1:0] slope_quot(logic signed [COORD_BITS+1:0] d,
                                                         logic [COORD_BITS:0] steps);
    logic [COORD_BITS+1:0]      mag;
    logic [COORD_BITS+FRAC:0]   num;
    logic [INC_W-1:0]           q;
    mag = (d < 0) ? -d : d;
    num = {mag[COORD_BITS:0], {FRAC{1'b0}}};
    q   = INC_W'(num / steps);
    return (d < 0) ? -$signed(q) : $signed(q);
  endfunction

  // floor(acc + 0.5), saturated to the coordinate range
  function automatic logic [COORD_BITS-1:0] round_half_up(logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0] v;
    logic signed [ACC_W:0] half;
    half           = '0;
    half[FRAC - 1] = 1'b1;
    v    = {acc[ACC_W-1], acc};
    v    = v + half;
    if (v < 0) return '0;
    v = v >>> FRAC;
    if (v > COORD_MAX) return '1;
    return v[COORD_BITS-1:0];
  endfunction

  // Current point, then advance the accumulators
  function automatic out_word_t emit_point(logic is_last);
    out_word_t r;
    r.valid_res = 1'b1;
    r.point_x   = round_half_up(ln_acc_x);
    r.point_y   = round_half_up(ln_acc_y);
    r.last      = is_last;
    ln_acc_x    = ln_acc_x + ln_inc_x;
    ln_acc_y    = ln_acc_y + ln_inc_y;
    return r;
  endfunction

  // Next result word of the line for one accepted input word
  function automatic out_word_t raster_next(in_word_t w);
    logic signed [COORD_BITS+1:0] dx;
    logic signed [COORD_BITS+1:0] dy;
    logic [COORD_BITS:0]          ax;
    logic [COORD_BITS:0]          ay;
    logic [COORD_BITS:0]          steps;
    out_word_t                    r;
    r = '0;
    if (w.func == FUNC_START) begin
      dx       = $signed({2'b00, w.x_end}) - $signed({2'b00, w.x_start});
      dy       = $signed({2'b00, w.y_end}) - $signed({2'b00, w.y_start});
      ax       = (COORD_BITS + 1)'((dx < 0) ? -dx : dx);
      ay       = (COORD_BITS + 1)'((dy < 0) ? -dy : dy);
      steps    = (ax > ay) ? ax : ay;
      ln_acc_x = {1'b0, w.x_start, {FRAC{1'b0}}};
      ln_acc_y = {1'b0, w.y_start, {FRAC{1'b0}}};
      if (steps == 0) begin
        // degenerate line: single point, no line left active
        ln_inc_x  = '0;
        ln_inc_y  = '0;
        ln_left   = '0;
        ln_active = 1'b0;
        r = emit_point(1'b1);
      end else begin
        ln_inc_x  = slope_quot(dx, steps);
        ln_inc_y  = slope_quot(dy, steps);
        ln_left   = steps;
        ln_active = 1'b1;
        n_lines++;
        r = emit_point(1'b0);
      end
    end else if (ln_active) begin
      ln_left = ln_left - 1'b1;
      if (ln_left == 0) begin
        ln_active = 1'b0;
        r = emit_point(1'b1);
      end else begin
        r = emit_point(1'b0);
      end
    end
    return r;
  endfunction

  function automatic in_word_t mk_word(logic f, int xs, int ys, int xe, int ye);
    in_word_t w;
    w.func    = f;
    w.x_start = COORD_BITS'(xs);
    w.y_start = COORD_BITS'(ys);
    w.x_end   = COORD_BITS'(xe);
    w.y_end   = COORD_BITS'(ye);
    return w;
  endfunction

  function automatic out_word_t mk_res(logic v, int px, int py, logic l);
    out_word_t r;
    r.valid_res = v;
    r.point_x   = COORD_BITS'(px);
    r.point_y   = COORD_BITS'(py);
    r.last      = l;
    return r;
  endfunction

  function automatic in_word_t rand_step();
    in_word_t w;
    w.func    = FUNC_STEP;
    w.x_start = COORD_BITS'($urandom);
    w.y_start = COORD_BITS'($urandom);
    w.x_end   = COORD_BITS'($urandom);
    w.y_end   = COORD_BITS'($urandom);
    return w;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Coordinate with a bias toward the range edges
  function automatic int pick_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 16) return COORD_MAX;
    return $urandom_range(0, COORD_MAX);
  endfunction

  function automatic int near_coord(int c, int span);
    int d;
    int v;
    d = $urandom_range(0, 2 * span) - span;
    v = c + d;
    if (v < 0 || v > COORD_MAX) v = c - d;
    return v;
  endfunction

  task automatic add_row(in_word_t w, bit typed, out_word_t r);
    dir_row_t row;
    row.word  = w;
    row.typed = typed;
    row.res   = r;
    dir_rows.push_back(row);
  endtask

  // Offer one word, wait for acceptance, then queue its expected result
  task automatic send_word(in_word_t w, bit typed, out_word_t r, bit no_gap);
    int        gap;
    out_word_t p;
    gap = (no_gap || hold_busy) ? 0 : pick_gap();
    if (gap > 0) begin
      push_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push_i    <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (full_o);
    p = raster_next(w);
    point_q.push_back(typed ? r : p);
    n_words++;
  endtask

  // Output monitor and no-progress watchdog
  always @(posedge clk_i) begin
    if (running) begin
      if (push_i && full_o) n_full++;
      if ((push_i && !full_o) || (pop_i && !empty_o)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= IDLE_MAX) begin
        $display("tb_dda_line_rasterizer: FAIL");
        $finish;
      end
      if (pop_i && !empty_o) begin
        got_w = out_word_o;
        if (point_q.size() == 0) begin
          $error("unexpected result word %h", got_w);
          n_errors++;
        end else begin
          want_w = point_q.pop_front();
          if (got_w.valid_res) n_points++;
          if (got_w.valid_res !== want_w.valid_res) begin
            $error("valid_res: expected %0d, got %0d", want_w.valid_res, got_w.valid_res);
            n_errors++;
          end
          if (got_w.point_x !== want_w.point_x) begin
            $error("point_x: expected %0d, got %0d", want_w.point_x, got_w.point_x);
            n_errors++;
          end
          if (got_w.point_y !== want_w.point_y) begin
            $error("point_y: expected %0d, got %0d", want_w.point_y, got_w.point_y);
            n_errors++;
          end
          if (got_w.last !== want_w.last) begin
            $error("last: expected %0d, got %0d", want_w.last, got_w.last);
            n_errors++;
          end
        end
      end
    end
  end

  // Receiver: random pop gaps and bursts, one long hold on request
  initial begin
    int g;
    int b;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !hold_done) begin
        hold_busy = 1'b1;
        pop_i <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk_i);
        hold_done = 1'b1;
        hold_busy = 1'b0;
      end else begin
        g = pick_gap();
        if (g > 0) begin
          pop_i <= 1'b0;
          repeat (g) @(posedge clk_i);
        end
        b = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
        pop_i <= 1'b1;
        repeat (b) @(posedge clk_i);
      end
    end
  end

  // Stimulus
  initial begin
    int        kind;
    int        n_steps;
    int        xs;
    int        ys;
    int        xe;
    int        ye;
    int        span;
    bit        burst;
    out_word_t none;
    none      = '0;
    n_errors  = 0;
    n_words   = 0;
    n_points  = 0;
    n_lines   = 0;
    n_full    = 0;
    idle_cnt  = 0;
    running   = 1'b0;
    hold_req  = 1'b0;
    hold_done = 1'b0;
    hold_busy = 1'b0;
    ln_acc_x  = '0;
    ln_acc_y  = '0;
    ln_inc_x  = '0;
    ln_inc_y  = '0;
    ln_left   = '0;
    ln_active = 1'b0;
    rst_ni    = 1'b0;
    push_i    = 1'b0;
    pop_i     = 1'b0;
    in_word_i = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    running = 1'b1;

    // Directed table
    add_row(mk_word(FUNC_STEP, 1023, 1023, 1023, 1023), 1, none);
    add_row(mk_word(FUNC_START, 0, 0, 0, 0), 1, mk_res(1, 0, 0, 1));
    add_row(mk_word(FUNC_STEP, 0, 0, 0, 0), 1, none);
    add_row(mk_word(FUNC_START, 1023, 1023, 1023, 1023), 1, mk_res(1, 1023, 1023, 1));
    add_row(mk_word(FUNC_START, 0, 0, 1023, 1023), 1, mk_res(1, 0, 0, 0));
    add_row(mk_word(FUNC_STEP, 1023, 0, 1023, 0), 0, none);
    add_row(mk_word(FUNC_STEP, 0, 1023, 0, 1023), 0, none);
    // restart in mid-line drops the old line
    add_row(mk_word(FUNC_START, 1023, 0, 0, 1023), 1, mk_res(1, 1023, 0, 0));
    add_row(mk_word(FUNC_STEP, 0, 0, 0, 0), 0, none);
    add_row(mk_word(FUNC_START, 1023, 1023, 0, 0), 1, mk_res(1, 1023, 1023, 0));
    add_row(mk_word(FUNC_STEP, 0, 0, 0, 0), 0, none);
    add_row(mk_word(FUNC_START, 5, 5, 8, 3), 0, none);
    add_row(mk_word(FUNC_STEP, 0, 0, 0, 0), 0, none);
    add_row(mk_word(FUNC_STEP, 0, 0, 0, 0), 0, none);
    add_row(mk_word(FUNC_STEP, 0, 0, 0, 0), 0, none);
    // line finished: step gives no point
    add_row(mk_word(FUNC_STEP, 0, 0, 0, 0), 1, none);
    add_row(mk_word(FUNC_START, 100, 200, 100, 201), 1, mk_res(1, 100, 200, 0));
    add_row(mk_word(FUNC_STEP, 0, 0, 0, 0), 1, mk_res(1, 100, 201, 1));
    add_row(mk_word(FUNC_START, 0, 1023, 1, 0), 0, none);
    add_row(mk_word(FUNC_STEP, 0, 0, 0, 0), 0, none);
    add_row(mk_word(FUNC_START, 512, 511, 300, 700), 0, none);
    add_row(mk_word(FUNC_STEP, 0, 0, 0, 0), 0, none);
    add_row(mk_word(FUNC_STEP, 0, 0, 0, 0), 0, none);
    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].res, 1'b0);
    end

    // Random line sequences
    while (n_words < dir_rows.size() + N_RANDOM) begin
      if (!hold_req && n_words > dir_rows.size() + N_RANDOM / 2) hold_req = 1'b1;
      burst = ($urandom_range(0, 3) == 0);
      kind  = $urandom_range(0, 99);
      if (kind < 88) begin
        xs = pick_coord();
        ys = pick_coord();
        if (kind < 70) span = $urandom_range(1, 12);
        else if (kind < 74) span = $urandom_range(40, 150);
        else if (kind < 80) span = -1;
        else span = 0;
        if (span < 0) begin
          xe = pick_coord();
          ye = pick_coord();
        end else begin
          xe = near_coord(xs, span);
          ye = near_coord(ys, span);
        end
        send_word(mk_word(FUNC_START, xs, ys, xe, ye), 1'b0, none, burst);
        n_steps = int'(ln_left);
        // far lines are cut short; some lines end early or overrun
        if (span < 0) n_steps = $urandom_range(0, 20);
        else if ($urandom_range(0, 9) == 0) n_steps = $urandom_range(0, n_steps);
        else if ($urandom_range(0, 9) == 0) n_steps = n_steps + $urandom_range(1, 3);
        repeat (n_steps) send_word(rand_step(), 1'b0, none, burst);
      end else begin
        repeat ($urandom_range(1, 3)) send_word(rand_step(), 1'b0, none, burst);
      end
    end
    push_i <= 1'b0;

    while (point_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("covered %0d words, %0d lines, %0d points, %0d input stall cycles",
             n_words, n_lines, n_points, n_full);
    $display("directed extremes and degenerate lines, then random lines with queue backpressure");
    if (n_errors == 0) begin
      $display("tb_dda_line_rasterizer: PASS");
    end else begin
      $display("tb_dda_line_rasterizer: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/dda_pkg.sv
rtl/dda_front.sv
rtl/dda_queue.sv
rtl/dda_div.sv
rtl/dda_back.sv
rtl/dda_line_rasterizer.sv
verif/tb_dda_line_rasterizer.sv
